### sv/tbo_pkg.sv
// Shared types and constants for the tetrahedron/box overlap classifier.
package tbo_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_EDGES = 4;

  // Descriptor layout, by word index
  localparam int W_LOWER = 0;
  localparam int W_UPPER = 3;
  localparam int W_NORM  = 6;
  localparam int W_OFFS  = 18;
  localparam int W_EDGE  = 22;
  localparam int W_COUNT = 58;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  localparam logic [1:0] REL_DISJOINT = 2'd0;
  localparam logic [1:0] REL_TETRA_IN = 2'd1;
  localparam logic [1:0] REL_BOX_IN   = 2'd2;
  localparam logic [1:0] REL_PARTIAL  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOW, OP_UPP, OP_PSET, OP_PTERM, OP_PCHK,
    OP_CNT, OP_ESET, OP_ETERM, OP_ECHK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       far;
  } dp_cmd_t;

  typedef struct packed {
    logic             dis;
    logic             tetra_in;
    logic             held_all;
    logic [2:0][2:0]  cnt;
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BND, S_PLN, S_CNT, S_EDG, S_WAIT, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_BND, PH_PLN, PH_CNT, PH_EDG
  } phase_t;

endpackage

### sv/tbo_dp.sv
// Datapath: descriptor store, box registers, shared multiply-accumulate and flags.
module tbo_dp import tbo_pkg::*; #(
  parameter int STORE_WORDS = 64,
  parameter int COORD_BITS  = 32,
  parameter int IW          = $clog2(STORE_WORDS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [5:0]                   slot,
  input  logic signed [COORD_BITS-1:0] word,
  input  logic                         capture,
  input  logic signed [COORD_BITS-1:0] low_x,
  input  logic signed [COORD_BITS-1:0] low_y,
  input  logic signed [COORD_BITS-1:0] low_z,
  input  logic signed [COORD_BITS-1:0] upp_x,
  input  logic signed [COORD_BITS-1:0] upp_y,
  input  logic signed [COORD_BITS-1:0] upp_z,
  input  logic [IW-1:0]                raddr,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat
);

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB;
  localparam int AW = 2 * CB + 3;

  logic signed [CB-1:0] mem [STORE_WORDS];
  logic signed [CB-1:0] rdata;
  dp_cmd_t              cmd_s1, cmd_s2;
  logic signed [CB-1:0] lo [3];
  logic signed [CB-1:0] up [3];
  logic signed [CB-1:0] tl [3];
  logic signed [CB-1:0] data_s2;
  logic signed [PW-1:0] prod_s2;
  logic signed [AW-1:0] sp, sn;
  logic                 dis, tetra_in;
  logic [2:0]           held;
  logic [2:0][2:0]      cnt;

  logic signed [CB-1:0] coord;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] scaled;
  logic signed [CB-1:0] il, iu;
  logic [2:0]           sat;

  always_ff @(posedge clk) begin
    if (load && (int'(slot) < STORE_WORDS)) begin
      mem[IW'(slot)] <= word;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      lo[0] <= low_x; lo[1] <= low_y; lo[2] <= low_z;
      up[0] <= upp_x; up[1] <= upp_y; up[2] <= upp_z;
    end
  end

  // stage 1: coordinate pick by coefficient sign, one product
  always_comb begin
    coord = lo[cmd_s1.axis];
    if (cmd_s1.op == OP_PTERM) begin
      coord = ((rdata < 0) == cmd_s1.far) ? lo[cmd_s1.axis] : up[cmd_s1.axis];
    end else if (cmd_s1.op == OP_ETERM) begin
      coord = (rdata > 0) ? up[cmd_s1.axis] : lo[cmd_s1.axis];
    end
    prod = PW'(rdata) * PW'(coord);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_s1 <= '{op: OP_NONE, axis: 2'd0, far: 1'b0};
      cmd_s2 <= '{op: OP_NONE, axis: 2'd0, far: 1'b0};
    end else begin
      cmd_s1 <= cmd;
      cmd_s2 <= cmd_s1;
    end
    data_s2 <= rdata;
    prod_s2 <= prod;
  end

  // stage 2: accumulate and flag updates
  always_comb begin
    scaled = AW'(data_s2) <<< FRAC_BITS;
    il  = (lo[cmd_s2.axis] > tl[cmd_s2.axis]) ? lo[cmd_s2.axis] : tl[cmd_s2.axis];
    iu  = (up[cmd_s2.axis] < data_s2) ? up[cmd_s2.axis] : data_s2;
    if (data_s2 < 0) begin
      sat = 3'd0;
    end else if (data_s2 > CB'(MAX_EDGES)) begin
      sat = 3'(MAX_EDGES);
    end else begin
      sat = data_s2[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dis      <= 1'b0;
      tetra_in <= 1'b1;
      held     <= 3'd0;
      cnt      <= '0;
    end else if (capture) begin
      dis      <= 1'b0;
      tetra_in <= 1'b1;
      held     <= 3'd0;
    end else begin
      case (cmd_s2.op)
        OP_UPP: begin
          if (il > iu) dis <= 1'b1;
          if (il != tl[cmd_s2.axis] || iu != data_s2) tetra_in <= 1'b0;
        end
        OP_PCHK: begin
          if (sp[AW-1]) dis <= 1'b1;
          if (!sn[AW-1]) held <= held + 3'd1;
        end
        OP_ECHK: begin
          if (sp[AW-1]) dis <= 1'b1;
        end
        OP_CNT: cnt[cmd_s2.axis] <= sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd_s2.op)
      OP_LOW: tl[cmd_s2.axis] <= data_s2;
      OP_PSET, OP_ESET: begin
        sp <= scaled;
        sn <= scaled;
      end
      OP_PTERM: begin
        if (cmd_s2.far) sp <= sp + AW'(prod_s2);
        else            sn <= sn + AW'(prod_s2);
      end
      OP_ETERM: sp <= sp + AW'(prod_s2);
      default: ;
    endcase
  end

  assign stat = '{dis: dis, tetra_in: tetra_in, held_all: (held == 3'd4), cnt: cnt};

  a_held_max: assert property (@(posedge clk) disable iff (rst) held <= 3'd4)
    else $error("plane hold count above four");
  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= 3'd4 && cnt[1] <= 3'd4 && cnt[2] <= 3'd4)
    else $error("edge count not saturated");
  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    capture |=> !dis && tetra_in && held == 3'd0)
    else $error("flags not cleared on new test");

endmodule

### sv/tbo_ctrl.sv
// Controller: sequences store reads and datapath operations, holds the result register.
module tbo_ctrl import tbo_pkg::*; #(
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          cmd,
  output logic          in_stall,
  output logic          load,
  output logic          capture,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    relation,
  output logic [IW-1:0] raddr,
  output dp_cmd_t       dcmd,
  input  dp_stat_t      stat
);

  state_t     state, state_next;
  phase_t     ph, ph_next;
  logic [2:0] stp, stp_next;
  logic [1:0] idx, idx_next;
  logic [2:0] ed, ed_next;
  logic [1:0] wcnt, wcnt_next;
  logic [1:0] res, res_next;
  logic       take;
  logic [1:0] ax_j, ax_k, pax;

  assign in_stall = (state != S_IDLE);
  assign load     = in_valid && !in_stall && (cmd == CMD_LOAD);
  assign capture  = in_valid && !in_stall && (cmd == CMD_TEST);
  assign take     = !out_valid || !out_stall;
  assign pax      = 2'((stp - 3'd1) >> 1);

  always_comb begin
    case (idx)
      2'd0:    begin ax_j = 2'd1; ax_k = 2'd2; end
      2'd1:    begin ax_j = 2'd2; ax_k = 2'd0; end
      default: begin ax_j = 2'd0; ax_k = 2'd1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= PH_BND;
      stp   <= 3'd0;
      idx   <= 2'd0;
      ed    <= 3'd0;
      wcnt  <= 2'd0;
      res   <= REL_DISJOINT;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      stp   <= stp_next;
      idx   <= idx_next;
      ed    <= ed_next;
      wcnt  <= wcnt_next;
      res   <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && take) relation <= res;
  end

  always_comb begin
    state_next = state;
    ph_next    = ph;
    stp_next   = stp;
    idx_next   = idx;
    ed_next    = ed;
    wcnt_next  = wcnt;
    res_next   = res;
    raddr      = '0;
    dcmd       = '{op: OP_NONE, axis: 2'd0, far: 1'b0};
    case (state)
      S_IDLE: begin
        if (capture) begin
          state_next = S_BND;
          stp_next   = 3'd0;
        end
      end
      S_BND: begin
        raddr     = IW'(stp);
        dcmd.op   = (stp < 3'd3) ? OP_LOW : OP_UPP;
        dcmd.axis = (stp < 3'd3) ? stp[1:0] : 2'(stp - 3'd3);
        stp_next  = stp + 3'd1;
        if (stp == 3'd5) begin
          state_next = S_WAIT;
          ph_next    = PH_BND;
          wcnt_next  = 2'd0;
        end
      end
      S_PLN: begin
        if (stp == 3'd0) begin
          raddr   = IW'(W_OFFS + int'(idx));
          dcmd.op = OP_PSET;
        end else if (stp == 3'd7) begin
          dcmd.op = OP_PCHK;
        end else begin
          raddr     = IW'(W_NORM + 3 * int'(idx) + int'(pax));
          dcmd.op   = OP_PTERM;
          dcmd.axis = pax;
          dcmd.far  = !stp[0] ? 1'b0 : 1'b1;
        end
        stp_next = stp + 3'd1;
        if (stp == 3'd7) begin
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            state_next = S_WAIT;
            ph_next    = PH_PLN;
            wcnt_next  = 2'd0;
          end
        end
      end
      S_CNT: begin
        raddr     = IW'(W_COUNT + int'(stp));
        dcmd.op   = OP_CNT;
        dcmd.axis = stp[1:0];
        stp_next  = stp + 3'd1;
        if (stp == 3'd2) begin
          state_next = S_WAIT;
          ph_next    = PH_CNT;
          wcnt_next  = 2'd0;
        end
      end
      S_EDG: begin
        if (idx == 2'd3) begin
          state_next = S_WAIT;
          ph_next    = PH_EDG;
          wcnt_next  = 2'd0;
        end else if (ed >= stat.cnt[idx]) begin
          idx_next = idx + 2'd1;
          ed_next  = 3'd0;
          stp_next = 3'd0;
        end else begin
          case (stp)
            3'd0: begin
              raddr   = IW'(W_EDGE + 12 * int'(idx) + 3 * int'(ed) + 2);
              dcmd.op = OP_ESET;
            end
            3'd1: begin
              raddr     = IW'(W_EDGE + 12 * int'(idx) + 3 * int'(ed));
              dcmd.op   = OP_ETERM;
              dcmd.axis = ax_j;
            end
            3'd2: begin
              raddr     = IW'(W_EDGE + 12 * int'(idx) + 3 * int'(ed) + 1);
              dcmd.op   = OP_ETERM;
              dcmd.axis = ax_k;
            end
            default: dcmd.op = OP_ECHK;
          endcase
          stp_next = stp + 3'd1;
          if (stp == 3'd3) begin
            stp_next = 3'd0;
            ed_next  = ed + 3'd1;
          end
        end
      end
      S_WAIT: begin
        wcnt_next = wcnt + 2'd1;
        if (wcnt == 2'd2) begin
          stp_next = 3'd0;
          idx_next = 2'd0;
          ed_next  = 3'd0;
          case (ph)
            PH_BND: begin
              if (stat.dis) begin
                state_next = S_FIN; res_next = REL_DISJOINT;
              end else if (stat.tetra_in) begin
                state_next = S_FIN; res_next = REL_TETRA_IN;
              end else begin
                state_next = S_PLN;
              end
            end
            PH_PLN: begin
              if (stat.dis) begin
                state_next = S_FIN; res_next = REL_DISJOINT;
              end else if (stat.held_all) begin
                state_next = S_FIN; res_next = REL_BOX_IN;
              end else begin
                state_next = S_CNT;
              end
            end
            PH_CNT: state_next = S_EDG;
            default: begin
              state_next = S_FIN;
              res_next   = stat.dis ? REL_DISJOINT : REL_PARTIAL;
            end
          endcase
        end
      end
      S_FIN: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_fin_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN && state_next == S_FIN) |-> (state == S_WAIT && wcnt == 2'd2))
    else $error("result decided before pipeline drained");
  a_edge_axis: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDG && dcmd.op != OP_NONE) |-> idx != 2'd3)
    else $error("edge read past last axis");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(relation))
    else $error("waiting result overwritten");

endmodule

### sv/tetra_box_overlap_classify.sv
// Top level of the tetrahedron/box overlap classifier.
// A load request (cmd 0) writes one descriptor word into the store;
// a slot at or beyond STORE_WORDS is dropped. A test request (cmd 1) takes the box
// corners and returns one relation: 0 disjoint, 1 tetrahedron inside box, 2 box
// inside tetrahedron, 3 partial. After acceptance a test runs the bounds pass (reads
// of the bounds, then a drain), the face plane tests, the fetch of the edge counts and
// then the silhouette edges, each set, given two terms and checked, with a drain after
// each pass; it may end after the bounds pass or the plane tests. The result is loaded
// into the result register, where it waits while the output is stalled. The sequence
// is set by the single read port of the descriptor store and the one shared multiplier,
// which walk the plane and edge equations term by term. One test is in flight at a time;
// the result register lets the next request in while the last result waits.
// Every store word a test reads must have been loaded since reset.
module tetra_box_overlap_classify import tbo_pkg::*; #(
  parameter int STORE_WORDS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [5:0]                   slot,
  input  logic signed [COORD_BITS-1:0] word,
  input  logic signed [COORD_BITS-1:0] low_x,
  input  logic signed [COORD_BITS-1:0] low_y,
  input  logic signed [COORD_BITS-1:0] low_z,
  input  logic signed [COORD_BITS-1:0] upp_x,
  input  logic signed [COORD_BITS-1:0] upp_y,
  input  logic signed [COORD_BITS-1:0] upp_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   relation
);

  localparam int IW = $clog2(STORE_WORDS);

  logic          load, capture;
  logic [IW-1:0] raddr;
  dp_cmd_t       dcmd;
  dp_stat_t      stat;

  // sequencer: bounds, planes, counts, edges, each followed by a drain
  tbo_ctrl #(.IW(IW)) u_ctrl (
    .clk, .rst, .in_valid, .cmd, .in_stall, .load, .capture,
    .out_valid, .out_stall, .relation, .raddr, .dcmd, .stat
  );

  // store, box registers and the shared dot unit
  tbo_dp #(.STORE_WORDS(STORE_WORDS), .COORD_BITS(COORD_BITS), .IW(IW)) u_dp (
    .clk, .rst, .load, .slot, .word, .capture,
    .low_x, .low_y, .low_z, .upp_x, .upp_y, .upp_z,
    .raddr, .cmd(dcmd), .stat
  );

endmodule
